// ----- design/gmcm_pkg.sv -----
// shared types, constants and field arithmetic for the gf(2^8) column mixer
package gmcm_pkg;

    localparam int unsigned NUM_BYTES = 4;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COL_W     = NUM_BYTES * BYTE_W;
    localparam int unsigned CFG_IDX_W = 2;

    // reducing polynomial x^8+x^4+x^3+x+1
    localparam logic [BYTE_W:0] POLY_REDUCE = 9'h11b;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW3 = 2'd3;

    // standard mixcolumns matrix, entry 0 in the top byte
    localparam logic [COL_W-1:0] MATRIX_ROW0_RESET = 32'h02030101;
    localparam logic [COL_W-1:0] MATRIX_ROW1_RESET = 32'h01020301;
    localparam logic [COL_W-1:0] MATRIX_ROW2_RESET = 32'h01010203;
    localparam logic [COL_W-1:0] MATRIX_ROW3_RESET = 32'h03010102;

    typedef logic [BYTE_W-1:0] t_byte;
    // byte times x^0 .. x^7 for each column element
    typedef t_byte t_powers [NUM_BYTES][BYTE_W];
    // one product per matrix entry, [row][column]
    typedef t_byte t_products [NUM_BYTES][NUM_BYTES];

    // multiply by x with reduction
    function automatic t_byte xtime(input t_byte b);
        t_byte s;
        s = {b[BYTE_W-2:0], 1'b0};
        if (b[BYTE_W-1]) begin
            s = s ^ POLY_REDUCE[BYTE_W-1:0];
        end
        return s;
    endfunction

endpackage

// ----- design/gf256_matrix_column_mix_top.sv -----
// gf(2^8) 4x4 matrix times column mixer, three-stage pipeline
//
// usage
//   input channel : i_valid / o_stall with i_column_in and i_last_column.
//     a column transfers at a rising edge with i_valid high and o_stall low.
//   output channel: o_valid / i_stall with o_column_out and o_last_out.
//     a result transfers at a rising edge with o_valid high and i_stall low.
//   config channel: i_cfg_valid / o_cfg_ready, i_cfg_index selects matrix row
//     0..3, i_cfg_data holds its four entries with entry 0 in bits 31..24.
//     ready is always high; write only while the pipeline is empty.
// timing
//   a transfer passes through the three register stages (x-power expansion,
//   per-entry products, row xor) in that order before o_valid rises. one column
//   is taken every cycle while o_stall is low; a held output backs the stages up.
// reset
//   synchronous active-low i_rst_n empties the pipeline and loads the
//   standard mixcolumns matrix.
// stall
//   a stalled result holds steady in the output register; bubbles in front
//   of it close up, and o_stall rises only once all three stages are full.
module gf256_matrix_column_mix_top
    import gmcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [COL_W-1:0]     i_column_in,
    input  logic                 i_last_column,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [COL_W-1:0]     o_column_out,
    output logic                 o_last_out,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COL_W-1:0]     i_cfg_data
);

    // matrix rows, entry 0 of each row in the top byte
    logic [COL_W-1:0] r_matrix [NUM_BYTES];

    // stage valid bits and pass-through flags
    logic r_v1, r_v2, r_v3;
    logic r_last1, r_last2, r_last3;

    // stage payloads
    t_powers          r_pow;
    t_powers          n_pow;
    t_products        r_prod;
    t_products        n_prod;
    logic [COL_W-1:0] r_col_out;
    logic [COL_W-1:0] n_col_out;

    // a stage loads when it is empty or its contents move on
    logic adv1, adv2, adv3;

    assign adv3 = !r_v3 || !i_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign o_stall     = !adv1;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix[REG_MATRIX_ROW0] <= MATRIX_ROW0_RESET;
            r_matrix[REG_MATRIX_ROW1] <= MATRIX_ROW1_RESET;
            r_matrix[REG_MATRIX_ROW2] <= MATRIX_ROW2_RESET;
            r_matrix[REG_MATRIX_ROW3] <= MATRIX_ROW3_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_matrix[i_cfg_index] <= i_cfg_data;
        end
    end

    // stage 1: each column element times x^0 .. x^7
    always_comb begin
        for (int c = 0; c < NUM_BYTES; c++) begin
            n_pow[c][0] = i_column_in[COL_W-1-BYTE_W*c -: BYTE_W];
            for (int k = 1; k < BYTE_W; k++) begin
                n_pow[c][k] = xtime(n_pow[c][k-1]);
            end
        end
    end

    // stage 2: product of each matrix entry with its column element,
    // xor of the x-powers picked by the entry's bits
    always_comb begin
        t_byte m;
        t_byte acc;
        for (int r = 0; r < NUM_BYTES; r++) begin
            for (int c = 0; c < NUM_BYTES; c++) begin
                m   = r_matrix[r][COL_W-1-BYTE_W*c -: BYTE_W];
                acc = '0;
                for (int k = 0; k < BYTE_W; k++) begin
                    acc = acc ^ (r_pow[c][k] & {BYTE_W{m[k]}});
                end
                n_prod[r][c] = acc;
            end
        end
    end

    // stage 3: xor the four products of each row
    always_comb begin
        t_byte acc;
        for (int r = 0; r < NUM_BYTES; r++) begin
            acc = '0;
            for (int c = 0; c < NUM_BYTES; c++) begin
                acc = acc ^ r_prod[r][c];
            end
            n_col_out[COL_W-1-BYTE_W*r -: BYTE_W] = acc;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // payload registers, loaded only with valid contents
    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_pow   <= n_pow;
            r_last1 <= i_last_column;
        end
        if (adv2 && r_v1) begin
            r_prod  <= n_prod;
            r_last2 <= r_last1;
        end
        if (adv3 && r_v2) begin
            r_col_out <= n_col_out;
            r_last3   <= r_last2;
        end
    end

    assign o_valid      = r_v3;
    assign o_column_out = r_col_out;
    assign o_last_out   = r_last3;

endmodule

// ----- design/gmcm_checker.sv -----
// port-level assertions for the column mixer and their bind
module gmcm_checker
    import gmcm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic [COL_W-1:0]     i_column_in,
    input logic                 i_last_column,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [COL_W-1:0]     o_column_out,
    input logic                 o_last_out,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready
);

    // a held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_column_out) && $stable(o_last_out))
        else $error("stalled result changed");

    // with an empty output stage nothing can back up to the input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output stage");

    // a transfer reaches the output with its last flag when i_stall stays low behind it
    a_latency_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall
        |=> o_valid && (o_last_out == $past(i_last_column, 3)))
        else $error("result missing or last flag wrong");

    // a zero column mixes to zero for any matrix
    a_zero_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_column_in == '0)) ##1 !i_stall ##1 !i_stall
        |=> o_valid && (o_column_out == '0))
        else $error("zero column gave nonzero result");

    // register writes are never held off
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write not accepted");

endmodule

bind gf256_matrix_column_mix_top gmcm_checker u_gmcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_column_in   (i_column_in),
    .i_last_column (i_last_column),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_column_out  (o_column_out),
    .o_last_out    (o_last_out),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);
